// ----- hdl/ufic_pkg.sv -----
// shared types and constants for the udp frame inject classifier
`default_nettype none
package ufic_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int ETH_HEADER_BYTES = 14;
  localparam int COUNT_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_FRAME_BYTES - 1);

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;

  // byte positions inside the frame
  localparam logic [COUNT_W-1:0] POS_ETYPE_HI = COUNT_W'(12);
  localparam logic [COUNT_W-1:0] POS_ETYPE_LO = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] POS_VIHL = COUNT_W'(ETH_HEADER_BYTES);
  localparam logic [COUNT_W-1:0] POS_PROTO = COUNT_W'(ETH_HEADER_BYTES + 9);
  localparam logic [COUNT_W-1:0] POS_DST_FIRST = COUNT_W'(ETH_HEADER_BYTES + 16);
  localparam logic [COUNT_W-1:0] POS_DST_LAST = COUNT_W'(ETH_HEADER_BYTES + 19);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [3:0] IP_VERSION_4 = 4'd4;
  localparam logic [5:0] IP_MIN_HDR = 6'd20;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [15:0] RST_LDN_PORT = 16'd11452;
  localparam logic [7:0] RST_LDN_MIN_PAYLOAD = 8'd12;
  localparam logic [15:0] RST_SUBNET_PREFIX = 16'd2573;

  typedef enum logic [3:0] {
    V_SHORT     = 4'd0,
    V_NOT_IPV4  = 4'd1,
    V_BAD_IP    = 4'd2,
    V_BAD_UDP   = 4'd3,
    V_ICMP      = 4'd4,
    V_OTHER     = 4'd5,
    V_BCAST     = 4'd6,
    V_LOOPBACK  = 4'd7,
    V_NO_PATH   = 4'd8
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INJECT_READY    = 8'd0,
    CFG_LDN_PORT        = 8'd1,
    CFG_LDN_MIN_PAYLOAD = 8'd2,
    CFG_SUBNET_PREFIX   = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic        inject_ready;
    logic [15:0] ldn_port;
    logic [7:0]  ldn_min_payload;
    logic [15:0] subnet_prefix;
  } cfg_regs_t;

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
    logic [15:0]        ethertype;
    logic [7:0]         version_and_ihl;
    logic [7:0]         ip_protocol;
    logic [31:0]        dest_address;
    logic [15:0]        udp_src;
    logic [15:0]        udp_dst;
    logic [15:0]        udp_length;
  } frame_t;

  typedef struct packed {
    verdict_t    verdict;
    logic        ldn_candidate;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [11:0] payload_offset;
    logic [11:0] payload_length;
  } result_t;

endpackage
`default_nettype wire

// ----- hdl/ufic_ifs.sv -----
// valid/ready channel interfaces for frame bytes, results and config writes
`default_nettype none
interface ufic_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ufic_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic        ldn_candidate;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [11:0] payload_offset;
  logic [11:0] payload_length;
  modport source (output valid, output verdict, output ldn_candidate, output source_port,
                  output dest_port, output payload_offset, output payload_length,
                  input ready);
  modport sink (input valid, input verdict, input ldn_candidate, input source_port,
                input dest_port, input payload_offset, input payload_length,
                output ready);
endinterface

interface ufic_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ufic_capture.sv -----
// byte counter and header field capture for the frame being received
`default_nettype none
module ufic_capture (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic          last_byte,
  input  wire logic [7:0]    data_byte,
  output ufic_pkg::frame_t   frame_next
);
  import ufic_pkg::*;

  frame_t                 frame;
  logic                   counting;
  logic [COUNT_W-1:0]     pos;
  logic [5:0]             hl;
  logic [COUNT_W-1:0]     udp_base;
  logic [COUNT_W:0]       udp_rel;
  logic                   in_udp;
  logic [1:0]             dst_lane;

  assign pos = frame.byte_count;
  assign counting = (frame.byte_count != COUNT_LIMIT);

  always_comb begin
    frame_next = frame;
    udp_base = '0;
    udp_rel = '0;
    in_udp = 1'b0;
    hl = '0;
    dst_lane = '0;
    if (counting) begin
      frame_next.byte_count = frame.byte_count + COUNT_W'(1);
      if (pos == POS_ETYPE_HI) frame_next.ethertype[15:8] = data_byte;
      if (pos == POS_ETYPE_LO) frame_next.ethertype[7:0] = data_byte;
      if (pos == POS_VIHL) frame_next.version_and_ihl = data_byte;
      if (pos == POS_PROTO) frame_next.ip_protocol = data_byte;
      if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) begin
        // first address byte lands in the top lane
        dst_lane = 2'(POS_DST_LAST - pos);
        unique case (dst_lane)
          2'd3: frame_next.dest_address[31:24] = data_byte;
          2'd2: frame_next.dest_address[23:16] = data_byte;
          2'd1: frame_next.dest_address[15:8] = data_byte;
          default: frame_next.dest_address[7:0] = data_byte;
        endcase
      end
      // header length follows the version byte written in this same cycle
      hl = {frame_next.version_and_ihl[3:0], 2'b00};
      udp_base = POS_VIHL + COUNT_W'(hl);
      udp_rel = {1'b0, pos} - {1'b0, udp_base};
      in_udp = !udp_rel[COUNT_W] && (udp_rel[COUNT_W-1:0] < COUNT_W'(6));
      if (in_udp) begin
        unique case (udp_rel[2:0])
          3'd0: frame_next.udp_src[15:8] = data_byte;
          3'd1: frame_next.udp_src[7:0] = data_byte;
          3'd2: frame_next.udp_dst[15:8] = data_byte;
          3'd3: frame_next.udp_dst[7:0] = data_byte;
          3'd4: frame_next.udp_length[15:8] = data_byte;
          default: frame_next.udp_length[7:0] = data_byte;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (take) begin
      if (last_byte) begin
        frame <= '0;
      end else begin
        frame <= frame_next;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ufic_classify.sv -----
// end-of-frame verdict and udp result fields from a captured header snapshot
`default_nettype none
module ufic_classify (
  input  wire ufic_pkg::frame_t    snap,
  input  wire ufic_pkg::cfg_regs_t cfg_regs,
  output ufic_pkg::result_t        result
);
  import ufic_pkg::*;

  logic [5:0]         hl;
  logic [COUNT_W-1:0] ip_len;
  logic [16:0]        udp_need;
  logic [15:0]        pl;
  logic               udp_fits;
  logic               bcast;

  assign hl = {snap.version_and_ihl[3:0], 2'b00};
  assign ip_len = snap.byte_count - COUNT_W'(ETH_HEADER_BYTES);
  assign udp_need = 17'(hl) + 17'(snap.udp_length);
  assign pl = snap.udp_length - UDP_HDR_BYTES;
  assign udp_fits = (17'(ip_len) >= 17'(hl) + 17'(UDP_HDR_BYTES));
  assign bcast = (snap.dest_address == ADDR_ALL_ONES) ||
                 (snap.dest_address[31:16] == cfg_regs.subnet_prefix);

  always_comb begin
    result = '0;
    result.verdict = V_SHORT;
    priority if (snap.byte_count <= COUNT_W'(ETH_HEADER_BYTES)) begin
      result.verdict = V_SHORT;
    end else if (snap.ethertype != ETHERTYPE_IPV4) begin
      result.verdict = V_NOT_IPV4;
    end else if (ip_len < COUNT_W'(IP_MIN_HDR) ||
                 snap.version_and_ihl[7:4] != IP_VERSION_4 || hl < IP_MIN_HDR) begin
      result.verdict = V_BAD_IP;
    end else if (snap.ip_protocol == PROTO_UDP && udp_fits) begin
      if (snap.udp_length <= UDP_HDR_BYTES || 17'(ip_len) < udp_need) begin
        result.verdict = V_BAD_UDP;
      end else begin
        result.ldn_candidate = (snap.udp_dst == cfg_regs.ldn_port) &&
                               (pl >= 16'(cfg_regs.ldn_min_payload));
        result.source_port = snap.udp_src;
        result.dest_port = snap.udp_dst;
        result.payload_offset = 12'(ETH_HEADER_BYTES) + 12'(hl) + 12'(UDP_HDR_BYTES);
        result.payload_length = pl[11:0];
        priority if (!cfg_regs.inject_ready) begin
          result.verdict = V_NO_PATH;
        end else if (bcast) begin
          result.verdict = V_BCAST;
        end else begin
          result.verdict = V_LOOPBACK;
        end
      end
    end else if (snap.ip_protocol == PROTO_ICMP) begin
      result.verdict = V_ICMP;
    end else begin
      result.verdict = V_OTHER;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/udp_frame_inject_classifier_top.sv -----
// top level: config registers, header capture, snapshot and result registers
// Frame bytes are taken one per cycle with no gaps between frames. On the byte
// marked last, the captured header fields are copied into a snapshot register
// and the per-frame state clears, so the first byte of the next frame can be
// taken in the very next cycle. The verdict is computed from the snapshot and
// lands in the result register when that register advances, so a result is
// offered to the sink once it has passed the snapshot and result registers. The
// snapshot and result registers form a two-deep buffer; bytes stall only when
// both are full and the sink is not taking a word. Config writes are always
// taken and apply to frames whose result has not yet been computed.
`default_nettype none
module udp_frame_inject_classifier_top (
  input  wire logic   clk,
  input  wire logic   rst,
  ufic_in_if.sink     frame_in,
  ufic_out_if.source  result_out,
  ufic_cfg_if.sink    cfg
);
  import ufic_pkg::*;

  cfg_regs_t cfg_regs;
  frame_t    frame_next;
  frame_t    snap;
  logic      snap_valid;
  result_t   result_next;
  result_t   result;
  logic      out_valid;
  logic      advance;
  logic      take;

  // config port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.inject_ready <= 1'b0;
      cfg_regs.ldn_port <= RST_LDN_PORT;
      cfg_regs.ldn_min_payload <= RST_LDN_MIN_PAYLOAD;
      cfg_regs.subnet_prefix <= RST_SUBNET_PREFIX;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_INJECT_READY:    cfg_regs.inject_ready <= cfg.data[0];
        CFG_LDN_PORT:        cfg_regs.ldn_port <= cfg.data;
        CFG_LDN_MIN_PAYLOAD: cfg_regs.ldn_min_payload <= cfg.data[7:0];
        CFG_SUBNET_PREFIX:   cfg_regs.subnet_prefix <= cfg.data;
        default: ;
      endcase
    end
  end

  // result register moves when empty or being taken
  assign advance = !out_valid || result_out.ready;
  assign frame_in.ready = !snap_valid || advance;
  assign take = frame_in.valid && frame_in.ready;

  ufic_capture u_capture (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .last_byte  (frame_in.last_byte),
    .data_byte  (frame_in.data_byte),
    .frame_next (frame_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= (take && frame_in.last_byte) || (snap_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take && frame_in.last_byte) begin
      snap <= frame_next;
    end
  end

  ufic_classify u_classify (
    .snap     (snap),
    .cfg_regs (cfg_regs),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && snap_valid) begin
      result <= result_next;
    end
  end

  assign result_out.valid = out_valid;
  assign result_out.verdict = result.verdict;
  assign result_out.ldn_candidate = result.ldn_candidate;
  assign result_out.source_port = result.source_port;
  assign result_out.dest_port = result.dest_port;
  assign result_out.payload_offset = result.payload_offset;
  assign result_out.payload_length = result.payload_length;

endmodule
`default_nettype wire
